>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the position controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/ppc_pkg.sv
// Types, constants and the clamp helper for the PID position controller.
// No dependencies.
`default_nettype none

package ppc_pkg;

    localparam int PID_SHIFT   = 8;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 15;
    localparam int POS_W       = 32;
    localparam int VAL_W       = 16;

    localparam logic [CFG_AW-1:0] REG_PROP_GAIN        = 3'd0;
    localparam logic [CFG_AW-1:0] REG_INTEG_GAIN       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DERIV_GAIN       = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ERROR_LIMIT      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_INTEGRAL_LIMIT   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DERIVATIVE_LIMIT = 3'd5;

    typedef logic signed [POS_W:0] wide_t;
    typedef logic signed [VAL_W-1:0] val_t;

    // Symmetric clamp to +/-lim; the result always fits 16 signed bits.
    function automatic val_t clamp_sym(input wide_t v, input logic [CFG_DW-1:0] lim);
        wide_t hi;
        wide_t lo;
        wide_t r;
        hi = $signed({{(POS_W+1-CFG_DW){1'b0}}, lim});
        lo = -hi;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pid_position_controller.sv
// PID position controller: input register, one pass of regulator logic, result register.
// Depends on ppc_pkg and assert_macros.svh.
//
// One item is one control tick and yields one result item. An accepted item waits in
// the input register until the result side can take it, then the position, target,
// clamped error, integral and difference and the three gain products are formed in a
// single pass and loaded into the result register together with the regulator state.
// A new item is taken every cycle while the result side keeps up. The user must write
// gains and limits through the write port only while no item is in flight; the block
// itself does not enforce this. s_tdata: measured_step [15:0], target_step [31:16];
// s_tuser: enabled. m_tdata: drive [15:0], position_now [47:16].
`default_nettype none

`include "assert_macros.svh"

module pid_position_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // measured_step [15:0], target_step [31:16]
    input  wire logic [0:0]  s_tuser,   // enabled [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // drive [15:0], position_now [47:16]
);

    // configuration
    logic [11:0] prop_gain_reg;
    logic [10:0] integ_gain_reg;
    logic [9:0]  deriv_gain_reg;
    logic [14:0] error_limit_reg;
    logic [14:0] integral_limit_reg;
    logic [14:0] derivative_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg        <= '0;
            integ_gain_reg       <= '0;
            deriv_gain_reg       <= '0;
            error_limit_reg      <= 15'd1023;
            integral_limit_reg   <= 15'd1023;
            derivative_limit_reg <= 15'd1023;
        end else if (cfg_we) begin
            case (cfg_addr)
                ppc_pkg::REG_PROP_GAIN:        prop_gain_reg        <= cfg_wdata[11:0];
                ppc_pkg::REG_INTEG_GAIN:       integ_gain_reg       <= cfg_wdata[10:0];
                ppc_pkg::REG_DERIV_GAIN:       deriv_gain_reg       <= cfg_wdata[9:0];
                ppc_pkg::REG_ERROR_LIMIT:      error_limit_reg      <= cfg_wdata;
                ppc_pkg::REG_INTEGRAL_LIMIT:   integral_limit_reg   <= cfg_wdata;
                ppc_pkg::REG_DERIVATIVE_LIMIT: derivative_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake
    logic        in_vld_reg;
    logic        out_vld_reg;
    logic        advance;
    logic        fire;
    logic [15:0] mstep_reg;
    logic [15:0] tstep_reg;
    logic        en_reg;

    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mstep_reg <= s_tdata[15:0];
            tstep_reg <= s_tdata[31:16];
            en_reg    <= s_tuser[0];
        end
    end

    // regulator state
    logic [31:0]     position_reg;
    logic [31:0]     target_reg;
    ppc_pkg::val_t   integral_reg;
    ppc_pkg::val_t   prev_err_reg;

    logic [31:0]     position_next;
    logic [31:0]     target_sum;
    logic [31:0]     target_next;
    logic [31:0]     err_raw;
    ppc_pkg::val_t   err_c;
    ppc_pkg::val_t   integ_c;
    ppc_pkg::val_t   diff_c;
    ppc_pkg::val_t   integral_next;
    ppc_pkg::val_t   prev_err_next;
    logic signed [28:0] p_term;
    logic signed [27:0] i_term;
    logic signed [26:0] d_term;
    logic signed [30:0] pid_sum;
    logic [15:0]     drive_next;

    always_comb begin
        position_next = position_reg + {{16{mstep_reg[15]}}, mstep_reg};
        target_sum    = target_reg + {{16{tstep_reg[15]}}, tstep_reg};
        err_raw       = target_sum - position_next;
        err_c   = ppc_pkg::clamp_sym($signed({err_raw[31], err_raw}), error_limit_reg);
        integ_c = ppc_pkg::clamp_sym(
            $signed({{17{integral_reg[15]}}, integral_reg})
                + $signed({{17{err_c[15]}}, err_c}), integral_limit_reg);
        diff_c  = ppc_pkg::clamp_sym(
            $signed({{17{err_c[15]}}, err_c})
                - $signed({{17{prev_err_reg[15]}}, prev_err_reg}), derivative_limit_reg);
        p_term  = err_c * $signed({1'b0, prop_gain_reg});
        i_term  = integ_c * $signed({1'b0, integ_gain_reg});
        d_term  = diff_c * $signed({1'b0, deriv_gain_reg});
        pid_sum = 31'(p_term) + 31'(i_term) + 31'(d_term);
        if (en_reg) begin
            target_next   = target_sum;
            integral_next = integ_c;
            prev_err_next = err_c;
            drive_next    = pid_sum[ppc_pkg::PID_SHIFT +: 16];
        end else begin
            target_next   = position_next;
            integral_next = '0;
            prev_err_next = '0;
            drive_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            target_reg   <= '0;
            integral_reg <= '0;
            prev_err_reg <= '0;
        end else if (fire) begin
            position_reg <= position_next;
            target_reg   <= target_next;
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
        end
    end

    // result register
    logic [47:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {position_next, drive_next};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_NEXT(a_disabled_clears, aclk, aresetn, fire && !en_reg,
        integral_reg == '0 && prev_err_reg == '0 && target_reg == position_reg)
    `ASSERT_NEXT(a_state_holds, aclk, aresetn, !fire, $stable(position_reg) && $stable(target_reg))
    `ASSERT_SAME(a_out_from_fire, aclk, aresetn, $rose(out_vld_reg), $past(fire))
    `ASSERT_NEXT(a_out_position, aclk, aresetn, fire, m_tdata[47:16] == position_reg)

endmodule

`default_nettype wire
